/* sv/tnon_pkg.sv */
package tnon_pkg;

  // Telnet command and option codes
  localparam logic [7:0] TN_IAC      = 8'd255;
  localparam logic [7:0] TN_DONT     = 8'd254;
  localparam logic [7:0] TN_DO       = 8'd253;
  localparam logic [7:0] TN_WONT     = 8'd252;
  localparam logic [7:0] TN_WILL     = 8'd251;
  localparam logic [7:0] TN_SB       = 8'd250;
  localparam logic [7:0] TN_SE       = 8'd240;
  localparam logic [7:0] TN_LINEMODE = 8'd34;

  // Input kinds (in_tuser)
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_NEWCONN = 1'b1;

  // Most result beats one job can produce: reply triple plus linemode request
  localparam int MAX_BEATS   = 6;
  localparam int BEAT_W      = $clog2(MAX_BEATS);
  localparam int QUEUE_DEPTH = 4;

  // One classified item, handed from parser to reply sequencer
  typedef struct packed {
    logic       has_triple;   // send IAC cmd opt
    logic [7:0] cmd;
    logic [7:0] opt;
    logic       has_ask;      // send IAC WILL LINEMODE after the triple
    logic       lm_on;
    logic       lm_refused;
    logic       lm_asked;
  } job_t;

endpackage

/* sv/telnet_option_negotiator.sv */
// Telnet option negotiator: parses IAC triples at buffer start, emits replies.
// Each job is registered in the queue, then its beats in the output register.
// Throughput: one input transaction per cycle while the job queue has room;
// output: one beat per cycle unless out_tready stalls; 1, 3 or 6 per input.
// Reset: synchronous, active-low rst_n clears parser state, flags and queue.
module telnet_option_negotiator #(
  parameter int QUEUE_DEPTH = tnon_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] op (1 = new connection)
  input  logic        in_tlast,   // buffer_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] reply_byte, [8] linemode_on,
                                  // [9] linemode_refused, [10] linemode_asked
  output logic        out_tuser,  // [0] reply_valid
  output logic        out_tlast   // last result of this input transaction
);
  import tnon_pkg::*;

  // Front end: parser state machine turns each accepted byte into one job
  // (optional reply triple, optional linemode request, flag snapshot).
  // Back end: sequencer walks a job out as individual reply bytes into the
  // output register. A small queue between them absorbs multi-byte replies
  // so byte parsing never waits on a busy output except when the queue fills.

  logic  accept;
  logic  push, pop, full, empty;
  job_t  push_job, head_job;
  logic [7:0] reply_byte;
  logic       reply_valid, last;
  logic [2:0] flags;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  tnon_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_tuser),
    .rx_byte    (in_tdata),
    .buffer_end (in_tlast),
    .push       (push),
    .push_job   (push_job)
  );

  tnon_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  tnon_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .empty       (empty),
    .pop         (pop),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .reply_byte  (reply_byte),
    .reply_valid (reply_valid),
    .last        (last),
    .flags       (flags)
  );

  // flags: {asked, refused, on}
  assign out_tdata = {5'd0, flags, reply_byte};
  assign out_tuser = reply_valid;
  assign out_tlast = last;

endmodule

/* sv/tnon_front.sv */
module tnon_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          op,
  input  logic [7:0]    rx_byte,
  input  logic          buffer_end,
  output logic          push,
  output tnon_pkg::job_t push_job
);
  import tnon_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_CMD,
    PH_OPT,
    PH_SUB,
    PH_IGNORE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       lm_r, lm_nxt;
  logic       ref_r, ref_nxt;
  logic       ask_r, ask_nxt;
  job_t       job;
  logic       is_lm;

  assign is_lm = (rx_byte == TN_LINEMODE);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    lm_nxt    = lm_r;
    ref_nxt   = ref_r;
    ask_nxt   = ask_r;
    job       = '0;

    if (op == OP_NEWCONN) begin
      phase_nxt = PH_START;
      held_nxt  = '0;
      lm_nxt    = 1'b0;
      ref_nxt   = 1'b0;
      ask_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_START: begin
          phase_nxt = (rx_byte == TN_IAC) ? PH_CMD : PH_IGNORE;
        end
        PH_CMD: begin
          if (rx_byte inside {TN_WILL, TN_WONT, TN_DO, TN_DONT}) begin
            held_nxt  = rx_byte;
            phase_nxt = PH_OPT;
          end else if (rx_byte == TN_SB) begin
            phase_nxt = PH_SUB;
          end else begin
            phase_nxt = PH_START;
          end
        end
        PH_OPT: begin
          phase_nxt = PH_START;
          job.opt   = rx_byte;
          if (held_r inside {TN_WILL, TN_DO}) begin
            if (is_lm) begin
              job.has_triple = !ask_r;
              job.cmd        = TN_WILL;
              lm_nxt         = 1'b1;
            end else begin
              job.has_triple = 1'b1;
              job.cmd        = (held_r == TN_WILL) ? TN_DONT : TN_WONT;
            end
          end else if (held_r == TN_WONT) begin
            if (is_lm) begin
              lm_nxt  = 1'b0;
              ref_nxt = 1'b1;
            end else begin
              job.has_triple = 1'b1;
              job.cmd        = TN_DONT;
            end
          end else if (held_r == TN_DONT) begin
            if (is_lm) begin
              lm_nxt  = 1'b0;
              ref_nxt = 1'b1;
            end
            job.has_triple = 1'b1;
            job.cmd        = TN_WONT;
          end
        end
        PH_SUB: begin
          if (rx_byte == TN_SE) begin
            phase_nxt = PH_START;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      // buffer end: one-time linemode request, parser restarts
      if (buffer_end) begin
        if (!lm_nxt && !ref_nxt && !ask_r) begin
          job.has_ask = 1'b1;
          ask_nxt     = 1'b1;
        end
        phase_nxt = PH_START;
        held_nxt  = '0;
      end
    end

    job.lm_on      = lm_nxt;
    job.lm_refused = ref_nxt;
    job.lm_asked   = ask_nxt;
  end

  assign push     = accept;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      held_r  <= '0;
      lm_r    <= 1'b0;
      ref_r   <= 1'b0;
      ask_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      lm_r    <= lm_nxt;
      ref_r   <= ref_nxt;
      ask_r   <= ask_nxt;
    end
  end

endmodule

/* sv/tnon_fifo.sv */
module tnon_fifo #(
  parameter int DEPTH = tnon_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tnon_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output tnon_pkg::job_t head_job,
  output logic           empty
);
  import tnon_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = CW'(count_r + 1'b1);
      2'b01:   count_nxt = CW'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/tnon_back.sv */
module tnon_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tnon_pkg::job_t head_job,
  input  logic           empty,
  output logic           pop,
  input  logic           out_tready,
  output logic           out_tvalid,
  output logic [7:0]     reply_byte,
  output logic           reply_valid,
  output logic           last,
  output logic [2:0]     flags
);
  import tnon_pkg::*;

  logic [BEAT_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r;
  logic [7:0]        byte_r;
  logic              rvalid_r, last_r;
  logic [2:0]        flags_r;

  logic [BEAT_W-1:0] n_beats;
  logic              last_beat, load, in_ask, any_reply;
  logic [1:0]        pos;
  logic [7:0]        beat_byte;

  always_comb begin
    case ({head_job.has_triple, head_job.has_ask})
      2'b00:   n_beats = BEAT_W'(1);
      2'b11:   n_beats = BEAT_W'(MAX_BEATS);
      default: n_beats = BEAT_W'(3);
    endcase
  end

  assign any_reply = head_job.has_triple | head_job.has_ask;
  assign last_beat = (idx_r == BEAT_W'(n_beats - 1'b1));

  always_comb begin
    if (head_job.has_triple && (idx_r < BEAT_W'(3))) begin
      in_ask = 1'b0;
      pos    = idx_r[1:0];
    end else begin
      in_ask = 1'b1;
      pos    = head_job.has_triple ? 2'(idx_r - BEAT_W'(3)) : idx_r[1:0];
    end
    case (pos)
      2'd0:    beat_byte = TN_IAC;
      2'd1:    beat_byte = in_ask ? TN_WILL : head_job.cmd;
      2'd2:    beat_byte = in_ask ? TN_LINEMODE : head_job.opt;
      default: beat_byte = '0;
    endcase
    if (!any_reply) begin
      beat_byte = '0;
    end
  end

  assign load    = (!out_valid_r || out_tready) && !empty;
  assign pop     = load && last_beat;
  assign idx_nxt = last_beat ? '0 : BEAT_W'(idx_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= beat_byte;
      rvalid_r <= any_reply;
      last_r   <= last_beat;
      flags_r  <= {head_job.lm_asked, head_job.lm_refused, head_job.lm_on};
    end
  end

  assign out_tvalid  = out_valid_r;
  assign reply_byte  = byte_r;
  assign reply_valid = rvalid_r;
  assign last        = last_r;
  assign flags       = flags_r;

endmodule
